>>> sv/vgbs_pkg.sv
// Shared constants, types and helper functions of the vector grid bilinear sampler.
// No dependencies; every other file of the block but vgbs_ram imports this package.
`default_nettype none

package vgbs_pkg;

	// Grid and store geometry.
	localparam int GRID_MAX    = 64;
	localparam int STORE_DEPTH = GRID_MAX * GRID_MAX;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CELL_W      = $clog2(GRID_MAX);
	localparam int GRID_W      = $clog2(GRID_MAX + 1);

	// Field widths.
	localparam int PIX_W   = 12;
	localparam int VEC_W   = 16;
	localparam int NODE_W  = 2 * VEC_W;
	localparam int COORD_W = 6;
	localparam int CFG_W   = 12;
	localparam int NCFG_W  = 7;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 32;

	// Arithmetic widths.
	localparam int FRAC_W  = 16;
	localparam int PX_W    = PIX_W + GRID_W;
	localparam int QUO_W   = PX_W + FRAC_W;
	localparam int WGT_W   = FRAC_W + 1;
	localparam int MUL_A_W = 34;
	localparam int ACC_W   = MUL_A_W + WGT_W + 1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_GRID_IN_USE   = 2'd2;

	// Item kinds carried on the input tuser.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PX,
		ST_PY,
		ST_DIVX,
		ST_DIVY,
		ST_CHECK,
		ST_READ,
		ST_MAC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

	// Round a sum with 32 fraction bits to the nearest integer, half up,
	// and saturate it to a signed 16-bit value.
	function automatic logic [VEC_W-1:0] round_sat(input logic signed [ACC_W-1:0] sum);
		logic signed [ACC_W-1:0]  biased;
		logic signed [ACC_W-33:0] q;
		logic [VEC_W-1:0]         res;
		biased = sum + (ACC_W'(1) <<< 31);
		q = $signed(biased[ACC_W-1:32]);
		if (q > $signed((ACC_W-32)'(32767))) begin
			res = 16'h7fff;
		end else if (q < $signed(-(ACC_W-32)'(32768))) begin
			res = 16'h8000;
		end else begin
			res = q[VEC_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> sv/vgbs_ram.sv
// Generic single-port RAM with a registered read port.
// Self-contained; used for the node vector store.
`default_nettype none

module vgbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

>>> sv/vgbs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on vgbs_pkg for the dividend and divisor widths.
`default_nettype none

module vgbs_div import vgbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QUO_W-1:0] dividend,
	input  logic [CFG_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic [CFG_W:0]   trial;
	logic             fits;

	// The quotient register starts as the dividend and shifts quotient bits in.
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[QUO_W-2:0], fits};
			rem_q <= fits ? CFG_W'(trial - {1'b0, dvs_q}) : trial[CFG_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> sv/vgbs_mac.sv
// Shared multiply-accumulate unit: a registered signed-by-unsigned product
// followed by an accumulator. Depends on vgbs_pkg for widths and the control struct.
`default_nettype none

module vgbs_mac import vgbs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mac_ctl_t                  ctl,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic [WGT_W-1:0]          b,
	output logic signed [ACC_W-1:0]   prod,
	output logic signed [ACC_W-1:0]   acc
);

	mac_ctl_t                ctl_s1;
	logic signed [ACC_W-1:0] prod_s1;
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_s1 <= a * $signed({1'b0, b});
		end
		if (ctl_s1.en) begin
			acc_q <= (ctl_s1.clr ? '0 : acc_q) + prod_s1;
		end
	end

	assign prod = prod_s1;
	assign acc  = acc_q;

endmodule

`default_nettype wire

>>> sv/vector_grid_bilinear_sampler_top.sv
// Top level of the vector grid bilinear sampler: sequencer, configuration registers,
// output register. Depends on vgbs_pkg, vgbs_ram, vgbs_div and vgbs_mac.
//
// Usage. The input stream carries two kinds of transaction, chosen by s_tuser.
// A write transaction stores one node vector in the node store and gives no
// result; it is taken in the idle state, which it does not leave, so the block stays ready.
// A query transaction gives exactly one output transaction: the bilinear blend
// of the four node vectors around the pixel point, or zero with m_tuser low
// when the point's cell lies outside the grid. Nodes must be written before a
// query reads them.
// Query flow. A query first divides the pixel position of each axis in turn in
// the bit-serial divider, which works through the quotient bits one by one; then
// come the four corner reads through the single store port and the twenty
// steps of the shared multiply-accumulate unit. A query whose cell lies outside
// the grid skips the reads and the blend. s_tready is low while a query is at
// work. A finished result sits in the output register, so the next item is
// accepted while it waits; if the receiver stalls, a second query completes its
// work and then holds until the first result has been taken.
// Reset clears the control state and loads the configuration reset values
// (1024, 768, 50). The configuration channel is always ready and must only be
// written while no query is in flight. The node store is not cleared.
`default_nettype none

module vector_grid_bilinear_sampler_top import vgbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Input stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	// s_tdata: node_col [5:0], node_row [11:6], node_vec_x [27:12],
	// node_vec_y [43:28], query_x [55:44], query_y [67:56], zero [71:68]
	input  logic [S_DATA_W-1:0] s_tdata,
	// s_tuser: func [0]
	input  logic [0:0]          s_tuser,
	// Output stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	// m_tdata: blend_x [15:0], blend_y [31:16]
	output logic [M_DATA_W-1:0] m_tdata,
	// m_tuser: inside_res [0]
	output logic [0:0]          m_tuser,
	// Configuration write channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	// Steps of one vector component in the multiply-accumulate sequence.
	localparam logic [3:0] MS_V0   = 4'd0;
	localparam logic [3:0] MS_V1   = 4'd1;
	localparam logic [3:0] MS_V2   = 4'd3;
	localparam logic [3:0] MS_V3   = 4'd4;
	localparam logic [3:0] MS_T0   = 4'd6;
	localparam logic [3:0] MS_T1   = 4'd7;
	localparam logic [3:0] MS_LAST = 4'd9;

	localparam logic [2:0] RD_LAST = 3'd4;

	state_t state_q, state_d;

	// Configuration registers.
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [NCFG_W-1:0] grid_q;
	logic [CFG_W-1:0]  w_eff;
	logic [CFG_W-1:0]  h_eff;
	logic [GRID_W-1:0] n_eff;

	// Input fields.
	logic               in_func;
	logic [COORD_W-1:0] in_col;
	logic [COORD_W-1:0] in_row;
	logic [NODE_W-1:0]  in_vec;
	logic [PIX_W-1:0]   in_qx;
	logic [PIX_W-1:0]   in_qy;
	logic               in_acc;

	// Query work registers.
	logic [PIX_W-1:0]  qx_q;
	logic [PIX_W-1:0]  qy_q;
	logic [QUO_W-1:0]  quo_x_q;
	logic [QUO_W-1:0]  quo_y_q;
	logic              inside_q;
	logic [2:0]        rd_cnt_q;
	logic [NODE_W-1:0] v_q [4];
	logic [3:0]        step_q;
	logic              comp_q;
	logic signed [MUL_A_W-1:0] t0_q;
	logic [VEC_W-1:0]  res_x_q;
	logic [VEC_W-1:0]  res_y_q;

	// Output register.
	logic              out_valid_q;
	logic [VEC_W-1:0]  blend_x_q;
	logic [VEC_W-1:0]  blend_y_q;
	logic              inside_out_q;

	// Datapath nets.
	logic [FRAC_W-1:0] fx, fy;
	logic [WGT_W-1:0]  gx, gy;
	logic [PX_W:0]     cx_next, cy_next;
	logic              outside;
	logic [CELL_W-1:0] cx, cy;
	logic [ADDR_W-1:0] wr_addr, rd_addr, ram_addr;
	logic              wr_ok, ram_we;
	logic [NODE_W-1:0] ram_rdata;
	logic [VEC_W-1:0]  vc [4];
	logic              out_free;

	mac_ctl_t                  mac_ctl;
	logic signed [MUL_A_W-1:0] mac_a;
	logic [WGT_W-1:0]          mac_b;
	logic signed [ACC_W-1:0]   mac_prod;
	logic signed [ACC_W-1:0]   mac_acc;

	logic              div_start;
	logic [QUO_W-1:0]  div_dividend;
	logic [CFG_W-1:0]  div_divisor;
	logic              div_done;
	logic [QUO_W-1:0]  div_quo;

	// The configuration port never stalls; the user must write it only while idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1024);
			height_q <= CFG_W'(768);
			grid_q   <= NCFG_W'(50);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				CFG_GRID_IN_USE:   grid_q   <= cfg_data[NCFG_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero screen size acts as one pixel and the grid size is clamped to 2..GRID_MAX, the row length of the store.
	assign w_eff = (width_q == '0) ? CFG_W'(1) : width_q;
	assign h_eff = (height_q == '0) ? CFG_W'(1) : height_q;

	always_comb begin
		if (grid_q < NCFG_W'(2)) begin
			n_eff = GRID_W'(2);
		end else if (32'(grid_q) > GRID_MAX) begin
			n_eff = GRID_W'(GRID_MAX);
		end else begin
			n_eff = GRID_W'(grid_q);
		end
	end

	assign in_func = s_tuser[0];
	assign in_col  = s_tdata[5:0];
	assign in_row  = s_tdata[11:6];
	assign in_vec  = s_tdata[43:12];
	assign in_qx   = s_tdata[55:44];
	assign in_qy   = s_tdata[67:56];
	assign in_acc  = s_tvalid && s_tready;

	// Each division yields the cell index above the fraction bits and the
	// position within the cell in the fraction bits.
	assign fx      = quo_x_q[FRAC_W-1:0];
	assign fy      = quo_y_q[FRAC_W-1:0];
	assign gx      = WGT_W'(1 << FRAC_W) - {1'b0, fx};
	assign gy      = WGT_W'(1 << FRAC_W) - {1'b0, fy};
	assign cx_next = {1'b0, quo_x_q[QUO_W-1:FRAC_W]} + (PX_W+1)'(1);
	assign cy_next = {1'b0, quo_y_q[QUO_W-1:FRAC_W]} + (PX_W+1)'(1);
	assign outside = (cx_next >= (PX_W+1)'(n_eff)) || (cy_next >= (PX_W+1)'(n_eff));
	assign cx      = quo_x_q[FRAC_W +: CELL_W];
	assign cy      = quo_y_q[FRAC_W +: CELL_W];

	// Node store addressing: row-major, GRID_MAX nodes per row.
	assign wr_ok   = (32'(in_col) < GRID_MAX) && (32'(in_row) < GRID_MAX);
	assign wr_addr = ADDR_W'(32'(in_row) * GRID_MAX + 32'(in_col));
	assign rd_addr = ADDR_W'((32'(cy) + 32'(rd_cnt_q[1])) * GRID_MAX
	                 + 32'(cx) + 32'(rd_cnt_q[0]));
	assign ram_addr = (state_q == ST_READ) ? rd_addr : wr_addr;
	assign ram_we   = in_acc && (in_func == FUNC_WRITE) && wr_ok;

	vgbs_ram #(
		.WIDTH(NODE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_vec),
		.rdata (ram_rdata)
	);

	assign div_dividend = {mac_prod[PX_W-1:0], FRAC_W'(0)};
	assign div_divisor  = (state_q == ST_PY) ? w_eff : h_eff;

	vgbs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	vgbs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.prod   (mac_prod),
		.acc    (mac_acc)
	);

	// Component of each corner vector for the pass in progress.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vc[k] = comp_q ? v_q[k][NODE_W-1:VEC_W] : v_q[k][VEC_W-1:0];
		end
	end

	assign out_free = !out_valid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && (in_func == FUNC_QUERY)) state_d = ST_PX;
			ST_PX:    state_d = ST_PY;
			ST_PY:    state_d = ST_DIVX;
			ST_DIVX:  if (div_done) state_d = ST_DIVY;
			ST_DIVY:  if (div_done) state_d = ST_CHECK;
			ST_CHECK: state_d = outside ? ST_FIN : ST_READ;
			ST_READ:  if (rd_cnt_q == RD_LAST) state_d = ST_MAC;
			ST_MAC:   if ((step_q == MS_LAST) && comp_q) state_d = ST_FIN;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs. Each component is blended first along x within the
	// two cell rows, then along y; the shared unit registers the product and then
	// the accumulator, so its result is readable once both registers have updated.
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		mac_ctl   = '0;
		mac_a     = '0;
		mac_b     = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_PX: begin
				mac_ctl.en = 1'b1;
				mac_a      = MUL_A_W'(qx_q);
				mac_b      = WGT_W'(n_eff);
			end
			ST_PY: begin
				mac_ctl.en = 1'b1;
				mac_a      = MUL_A_W'(qy_q);
				mac_b      = WGT_W'(n_eff);
				div_start  = 1'b1;
			end
			ST_DIVX: div_start = div_done;
			ST_MAC: begin
				case (step_q)
					MS_V0: begin
						mac_ctl = '{en: 1'b1, clr: 1'b1};
						mac_a   = MUL_A_W'($signed(vc[0]));
						mac_b   = gx;
					end
					MS_V1: begin
						mac_ctl.en = 1'b1;
						mac_a      = MUL_A_W'($signed(vc[1]));
						mac_b      = {1'b0, fx};
					end
					MS_V2: begin
						mac_ctl = '{en: 1'b1, clr: 1'b1};
						mac_a   = MUL_A_W'($signed(vc[2]));
						mac_b   = gx;
					end
					MS_V3: begin
						mac_ctl.en = 1'b1;
						mac_a      = MUL_A_W'($signed(vc[3]));
						mac_b      = {1'b0, fx};
					end
					MS_T0: begin
						mac_ctl = '{en: 1'b1, clr: 1'b1};
						mac_a   = t0_q;
						mac_b   = gy;
					end
					MS_T1: begin
						// The accumulator still holds the lower row blend here.
						mac_ctl.en = 1'b1;
						mac_a      = mac_acc[MUL_A_W-1:0];
						mac_b      = {1'b0, fy};
					end
					default: ;
				endcase
			end
			ST_DIVY, ST_CHECK, ST_READ, ST_FIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			step_q      <= '0;
			comp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK) begin
				rd_cnt_q <= '0;
				step_q   <= '0;
				comp_q   <= 1'b0;
			end
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
			end
			if (state_q == ST_MAC) begin
				if (step_q == MS_LAST) begin
					step_q <= '0;
					comp_q <= 1'b1;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (in_func == FUNC_QUERY)) begin
			qx_q <= in_qx;
			qy_q <= in_qy;
		end
		if ((state_q == ST_DIVX) && div_done) begin
			quo_x_q <= div_quo;
		end
		if ((state_q == ST_DIVY) && div_done) begin
			quo_y_q <= div_quo;
		end
		if (state_q == ST_CHECK) begin
			inside_q <= !outside;
		end
		if ((state_q == ST_READ) && (rd_cnt_q != '0)) begin
			v_q[2'(rd_cnt_q - 3'd1)] <= ram_rdata;
		end
		if ((state_q == ST_MAC) && (step_q == MS_V2)) begin
			t0_q <= mac_acc[MUL_A_W-1:0];
		end
		if ((state_q == ST_MAC) && (step_q == MS_LAST)) begin
			if (comp_q) begin
				res_y_q <= round_sat(mac_acc);
			end else begin
				res_x_q <= round_sat(mac_acc);
			end
		end
		if ((state_q == ST_FIN) && out_free) begin
			blend_x_q    <= inside_q ? res_x_q : '0;
			blend_y_q    <= inside_q ? res_y_q : '0;
			inside_out_q <= inside_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {blend_y_q, blend_x_q};
	assign m_tuser  = inside_out_q;

	// A query transaction always leaves the idle state on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_func == FUNC_QUERY)) |=> (state_q == ST_PX))
		else $error("query accepted but sequencer did not start");

	// The node store is only written while no query owns the address port.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("node store written during a query");

	// A result for a point outside the grid carries zero vectors.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("outside result with nonzero blend");

	// A finished query waits while the previous result is still pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && out_valid_q && !m_tready) |=> (state_q == ST_FIN))
		else $error("result register overwritten before it was taken");

	// The divider only reports completion while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == ST_DIVX) || (state_q == ST_DIVY)))
		else $error("divider completion outside a division state");

endmodule

`default_nettype wire

>>> bench/vector_grid_bilinear_sampler_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for vector_grid_bilinear_sampler_top: node writes and point queries
// under several screen and grid settings, compared against a built-in bilinear predictor.
// Depends on vgbs_pkg and the sampler RTL only.

module vector_grid_bilinear_sampler_top_test;
	import vgbs_pkg::*;

	// Time that a query result takes from acceptance to m_tvalid.
	localparam int QUERY_LAT   = 2 * QUO_W + 31;
	// The receiver stalls once for this long so that the block backs up.
	localparam int HOLD_CYCLES = 600;
	// Cycles without any transaction before the run is declared hung.
	localparam int IDLE_LIMIT  = 5000;
	// Register index that the block does not implement; writes to it are dropped.
	localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct packed {
		logic               func;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [VEC_W-1:0]   vx;
		logic [VEC_W-1:0]   vy;
		logic [PIX_W-1:0]   qx;
		logic [PIX_W-1:0]   qy;
	} grid_item_t;

	typedef struct packed {
		logic [VEC_W-1:0] bx;
		logic [VEC_W-1:0] by;
		logic             in_grid;
	} blend_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic [0:0]          s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [0:0]          m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data  = '0;

	vector_grid_bilinear_sampler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow of the block: node store and configuration as seen at accepted transactions.
	logic [NODE_W-1:0] node_mem [STORE_DEPTH];
	logic [CFG_W-1:0]  cfg_w = 12'd1024;
	logic [CFG_W-1:0]  cfg_h = 12'd768;
	logic [NCFG_W-1:0] cfg_n = 7'd50;

	// Nodes already queued for writing; the stimulus never lets a query read any other node.
	bit gen_written [STORE_DEPTH];

	grid_item_t pending [$];
	blend_t     blend_q [$];
	grid_item_t cur_item;

	bit in_acc;
	bit gaps_on  = 1'b1;
	bit pressure = 1'b0;
	bit held     = 1'b0;
	int tx_gap, rx_gap, hold_left;
	int cfg_taken, idle_cycles;
	int err_cnt, mism_cnt, n_writes, n_queries, n_inside, n_outside, n_settings;

	// ------------------------------------------------------------------
	// Bilinear predictor
	// ------------------------------------------------------------------

	// A zero screen size behaves as one pixel.
	function automatic longint eff_dim(input logic [CFG_W-1:0] v);
		return (v == 0) ? 1 : longint'(v);
	endfunction

	// The grid size is clamped to 2..GRID_MAX.
	function automatic longint eff_grid(input logic [NCFG_W-1:0] v);
		if (v < 2) return 2;
		if (v > GRID_MAX) return GRID_MAX;
		return longint'(v);
	endfunction

	function automatic longint cell_index(input logic [PIX_W-1:0] q, input longint dim,
		input longint n);
		return (longint'(q) * n) / dim;
	endfunction

	// Largest pixel coordinate whose cell still has a right or lower neighbor.
	function automatic int last_inside(input logic [CFG_W-1:0] dim_reg,
		input logic [NCFG_W-1:0] n_reg);
		longint d, n, x;
		d = eff_dim(dim_reg);
		n = eff_grid(n_reg);
		x = ((n - 1) * d + n - 1) / n - 1;
		return (x > 4095) ? 4095 : int'(x);
	endfunction

	// Drop 32 fraction bits with round half up, then clamp to signed Q8.8.
	function automatic logic [VEC_W-1:0] round_q88(input longint s);
		longint q;
		q = (s + 64'sd2147483648) >>> 32;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[VEC_W-1:0];
	endfunction

	function automatic blend_t sample_field(input logic [PIX_W-1:0] qx,
		input logic [PIX_W-1:0] qy);
		longint w, h, n, px, py, cx, cy, fx, fy, gx, gy, sx, sy;
		longint wt [4];
		logic [NODE_W-1:0] corner [4];
		blend_t r;
		w = eff_dim(cfg_w);
		h = eff_dim(cfg_h);
		n = eff_grid(cfg_n);
		px = longint'(qx) * n;
		py = longint'(qy) * n;
		cx = px / w;
		cy = py / h;
		r = '0;
		if (cx + 1 >= n || cy + 1 >= n) return r;
		fx = ((px % w) << 16) / w;
		fy = ((py % h) << 16) / h;
		gx = 65536 - fx;
		gy = 65536 - fy;
		wt[0] = gx * gy;
		wt[1] = fx * gy;
		wt[2] = gx * fy;
		wt[3] = fx * fy;
		corner[0] = node_mem[cy * GRID_MAX + cx];
		corner[1] = node_mem[cy * GRID_MAX + cx + 1];
		corner[2] = node_mem[(cy + 1) * GRID_MAX + cx];
		corner[3] = node_mem[(cy + 1) * GRID_MAX + cx + 1];
		sx = 0;
		sy = 0;
		for (int k = 0; k < 4; k++) begin
			sx += longint'($signed(corner[k][VEC_W-1:0])) * wt[k];
			sy += longint'($signed(corner[k][NODE_W-1:VEC_W])) * wt[k];
		end
		r.bx = round_q88(sx);
		r.by = round_q88(sy);
		r.in_grid = 1'b1;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: samples every handshake at the rising edge, updates the
	// shadow state and checks results in order.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		blend_t exp_res;
		bit     any_txn;
		in_acc <= s_tvalid && s_tready;
		if (arst_n) begin
			any_txn = 1'b0;
			if (cfg_valid && cfg_ready) begin
				any_txn = 1'b1;
				case (cfg_index)
					CFG_SCREEN_WIDTH: begin
						cfg_w = cfg_data;
					end
					CFG_SCREEN_HEIGHT: begin
						cfg_h = cfg_data;
					end
					CFG_GRID_IN_USE: begin
						cfg_n = cfg_data[NCFG_W-1:0];
					end
					default: begin
					end
				endcase
				cfg_taken <= cfg_taken + 1;
			end
			if (s_tvalid && s_tready) begin
				any_txn = 1'b1;
				if (cur_item.func == FUNC_WRITE) begin
					node_mem[{cur_item.row, cur_item.col}] = {cur_item.vy, cur_item.vx};
					n_writes++;
				end else begin
					exp_res = sample_field(cur_item.qx, cur_item.qy);
					blend_q.insert(blend_q.size(), exp_res);
					n_queries++;
					if (exp_res.in_grid) n_inside++;
					else n_outside++;
				end
			end
			if (m_tvalid && m_tready) begin
				any_txn = 1'b1;
				if (blend_q.size() == 0) begin
					err_cnt++;
					if (mism_cnt < 10)
						$display("Unexpected result transaction: data %h user %b",
							m_tdata, m_tuser);
					mism_cnt++;
				end else begin
					exp_res = blend_q.pop_front();
					if (m_tdata[VEC_W-1:0] !== exp_res.bx ||
						m_tdata[M_DATA_W-1:VEC_W] !== exp_res.by ||
						m_tuser[0] !== exp_res.in_grid) begin
						err_cnt++;
						if (mism_cnt < 10)
							$display("Mismatch: blend_x exp %h got %h, blend_y exp %h got %h, %s",
								exp_res.bx, m_tdata[VEC_W-1:0],
								exp_res.by, m_tdata[M_DATA_W-1:VEC_W],
								$sformatf("inside exp %b got %b", exp_res.in_grid, m_tuser[0]));
						mism_cnt++;
					end
				end
			end
			idle_cycles <= any_txn ? 0 : idle_cycles + 1;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued items at the falling edge and holds each one
	// until its transaction has been seen at a rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!s_tvalid || in_acc) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (pending.size() != 0) begin
				cur_item = pending.pop_front();
				s_tdata  <= {4'b0, cur_item.qy, cur_item.qx, cur_item.vy, cur_item.vx,
					cur_item.row, cur_item.col};
				s_tuser  <= cur_item.func;
				s_tvalid <= 1'b1;
				tx_gap = (gaps_on && $urandom_range(0, 1) == 0) ? gap_len() : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold when the pressure
	// phase starts so that results pile up and the input side stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (pressure && !held) begin
			held = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (gaps_on && $urandom_range(0, 3) == 0) rx_gap = gap_len();
		end
	end

	// Watchdog: a run with no transaction for too long has hung.
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	// Vector component with extra weight on the Q8.8 extremes and zero.
	function automatic logic [VEC_W-1:0] rand_vec();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return VEC_W'($urandom);
		endcase
	endfunction

	task automatic push_write(input int col, input int row, input logic [VEC_W-1:0] vx,
		input logic [VEC_W-1:0] vy);
		grid_item_t it;
		it.func = FUNC_WRITE;
		it.col  = COORD_W'(col);
		it.row  = COORD_W'(row);
		it.vx   = vx;
		it.vy   = vy;
		// The point fields are ignored on a write; fill them with noise.
		it.qx   = PIX_W'($urandom);
		it.qy   = PIX_W'($urandom);
		gen_written[row * GRID_MAX + col] = 1'b1;
		pending.insert(pending.size(), it);
	endtask

	// Queue a query, preceded, when its cell lies inside the grid, by writes of any
	// of its four corners that have not been queued for writing yet.
	task automatic push_query(input int qx, input int qy);
		grid_item_t it;
		longint n, cx, cy;
		n  = eff_grid(cfg_n);
		cx = cell_index(PIX_W'(qx), eff_dim(cfg_w), n);
		cy = cell_index(PIX_W'(qy), eff_dim(cfg_h), n);
		if (cx + 1 < n && cy + 1 < n) begin
			for (int dy = 0; dy < 2; dy++)
				for (int dx = 0; dx < 2; dx++)
					if (!gen_written[(cy + dy) * GRID_MAX + cx + dx])
						push_write(int'(cx) + dx, int'(cy) + dy, rand_vec(), rand_vec());
		end
		it.func = FUNC_QUERY;
		it.col  = COORD_W'($urandom);
		it.row  = COORD_W'($urandom);
		it.vx   = VEC_W'($urandom);
		it.vy   = VEC_W'($urandom);
		it.qx   = PIX_W'(qx);
		it.qy   = PIX_W'(qy);
		pending.insert(pending.size(), it);
	endtask

	// Random mix: a quarter node writes anywhere, the rest queries, most of
	// them aimed inside the grid and some over the whole coordinate range.
	task automatic random_items(input int count);
		int lx, ly;
		lx = last_inside(cfg_w, cfg_n);
		ly = last_inside(cfg_h, cfg_n);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				push_write($urandom_range(0, GRID_MAX - 1), $urandom_range(0, GRID_MAX - 1),
					rand_vec(), rand_vec());
			else if ($urandom_range(0, 3) != 0)
				push_query($urandom_range(0, lx), $urandom_range(0, ly));
			else
				push_query($urandom_range(0, 4095), $urandom_range(0, 4095));
		end
	endtask

	// Wait until every item is taken and every result has arrived, then give
	// the block more than a further query latency before anything changes.
	task automatic drain();
		do @(posedge clk);
		while (pending.size() != 0 || s_tvalid || blend_q.size() != 0);
		repeat (QUERY_LAT + 8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		int seen;
		seen = cfg_taken;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		wait (cfg_taken != seen);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reconfigure only once the block has gone quiet.
	task automatic apply_cfg(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
		input logic [CFG_W-1:0] g);
		drain();
		gaps_on  = 1'b1;
		pressure = 1'b0;
		write_cfg(CFG_SCREEN_WIDTH, w);
		write_cfg(CFG_SCREEN_HEIGHT, h);
		write_cfg(CFG_GRID_IN_USE, g);
		n_settings++;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int lx, ly;
		n_settings = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration, 1024 x 768 with 50 nodes. The first cell gets
		// the extreme vectors so that the blend sees full-scale corners.
		push_write(0, 0, 16'h7fff, 16'h8000);
		push_write(1, 0, 16'h8000, 16'h7fff);
		push_write(0, 1, 16'h0000, 16'hffff);
		push_write(1, 1, 16'hffff, 16'h0000);
		push_query(0, 0);
		push_query(10, 7);
		push_query(20, 15);
		// Points past the grid on one axis or both.
		push_query(4095, 4095);
		push_query(4095, 0);
		push_query(0, 4095);
		// Last cell that still has neighbors, and the first ones that do not.
		lx = last_inside(cfg_w, cfg_n);
		ly = last_inside(cfg_h, cfg_n);
		push_query(lx, ly);
		push_query(lx + 1, ly);
		push_query(lx, ly + 1);
		push_write(GRID_MAX - 1, GRID_MAX - 1, 16'h5555, 16'haaaa);
		random_items(25);

		// Largest screen and a full grid; the last cell reads the far corner node.
		apply_cfg(12'd4095, 12'd4095, 12'd64);
		lx = last_inside(cfg_w, cfg_n);
		push_query(lx, lx);
		push_query(4095, 4095);
		random_items(20);

		// Single-pixel screen, grid size below the minimum.
		apply_cfg(12'd1, 12'd1, 12'd1);
		push_query(0, 0);
		push_query(1, 0);
		random_items(10);

		// Zero sizes everywhere, plus a write to an index the block lacks.
		apply_cfg(12'd0, 12'd0, 12'd0);
		write_cfg(CFG_UNUSED_IDX, CFG_W'($urandom));
		push_query(0, 0);
		random_items(10);

		// Grid size above the maximum. The sender goes flat out while the
		// receiver holds off, so results back up into the input.
		apply_cfg(12'd100, 12'd37, 12'd127);
		gaps_on  = 1'b0;
		pressure = 1'b1;
		random_items(30);

		// A stretch with no idling on either side.
		apply_cfg(12'd640, 12'd480, 12'd16);
		gaps_on = 1'b0;
		random_items(25);

		// Random settings; the grid write carries noise in the data bits above the register too.
		repeat (2) begin
			apply_cfg(CFG_W'($urandom_range(1, 4095)), CFG_W'($urandom_range(1, 4095)),
				CFG_W'($urandom));
			random_items(20);
		end

		drain();
		$display("Covered %0d node writes and %0d queries (%0d inside, %0d outside the grid)",
			n_writes, n_queries, n_inside, n_outside);
		$display("over %0d grid settings, with a %0d-cycle output stall; %0d errors.",
			n_settings, HOLD_CYCLES, err_cnt);
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> files.f
sv/vgbs_pkg.sv
sv/vgbs_ram.sv
sv/vgbs_div.sv
sv/vgbs_mac.sv
sv/vector_grid_bilinear_sampler_top.sv
bench/vector_grid_bilinear_sampler_top_test.sv
